### design/jsp_pkg.sv
// Shared types, constants and register codes for the joystick servo positioner.
package jsp_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int CHANNEL_W   = 3;
  localparam int ANGLE_W     = 8;
  localparam int PULSE_W     = 14;
  localparam int THRESH_W    = 12;
  localparam int TPD_W       = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [ANGLE_W-1:0]   ANGLE_MAX       = 8'd180;
  localparam logic [CHANNEL_W-1:0] STEPPER_CHANNEL = 3'd0;
  localparam logic [CHANNEL_W-1:0] MIRROR_CHANNEL  = 3'd2;

  localparam logic                 RESET_FINE_MODE      = 1'b0;
  localparam logic [CHANNEL_W-1:0] RESET_REPORT_CHANNEL = 3'd5;
  localparam logic [THRESH_W-1:0]  RESET_RAISE          = 12'd3000;
  localparam logic [THRESH_W-1:0]  RESET_LOWER          = 12'd1000;
  localparam logic [THRESH_W-1:0]  RESET_STEP_BACK      = 12'd1500;
  localparam logic [THRESH_W-1:0]  RESET_STEP_FWD       = 12'd2500;
  localparam logic [THRESH_W-1:0]  RESET_PULSE_BASE     = 12'd500;
  localparam logic [TPD_W-1:0]     RESET_TICKS_PER_DEG  = 6'd11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FINE_MODE,
    REG_REPORT_CHANNEL,
    REG_RAISE_THRESHOLD,
    REG_LOWER_THRESHOLD,
    REG_STEP_BACK_THRESHOLD,
    REG_STEP_FWD_THRESHOLD,
    REG_PULSE_BASE,
    REG_TICKS_PER_DEGREE
  } reg_index_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_STEP_BACK,
    OP_STEP_FWD,
    OP_SERVO_ABS,
    OP_SERVO_FINE
  } op_t;

  typedef enum logic [1:0] {
    NUDGE_HOLD,
    NUDGE_UP,
    NUDGE_DOWN
  } nudge_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0]   channel;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                 servo_update;
    logic [2:0]           servo_index;
    logic [PULSE_W-1:0]   pulse_ticks;
    logic                 step_pulse;
    logic                 step_dir;
    logic                 report_valid;
    logic [ANGLE_W-1:0]   report_angle;
  } result_t;

  typedef struct packed {
    logic                 fine_mode;
    logic [CHANNEL_W-1:0] report_channel;
    logic [THRESH_W-1:0]  raise_threshold;
    logic [THRESH_W-1:0]  lower_threshold;
    logic [THRESH_W-1:0]  step_back_threshold;
    logic [THRESH_W-1:0]  step_fwd_threshold;
    logic [THRESH_W-1:0]  pulse_base;
    logic [TPD_W-1:0]     ticks_per_degree;
  } cfg_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    op_t                op;
    nudge_t             nudge;
    logic               report;
    logic [2:0]         servo_index;
    logic [ANGLE_W-1:0] abs_angle;
  } work_t;

endpackage

### design/jsp_fifo.sv
// Small first-in first-out queue held in flip-flops.
module jsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

### design/jsp_front.sv
// Front part: accepts samples, classifies them and maps samples to absolute angles.
module jsp_front #(
  parameter int SERVO_COUNT = 6,
  parameter int MID_DEPTH   = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  jsp_pkg::in_item_t              item,
  output logic                           full,
  input  jsp_pkg::cfg_t                  cfg,
  input  logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
  output logic                           mid_push,
  output jsp_pkg::work_t                 mid_item
);

  localparam int SB     = jsp_pkg::SAMPLE_BITS;
  localparam int AW     = jsp_pkg::ANGLE_W;
  localparam int PROD_W = SB + AW;
  localparam int CNT_W  = $clog2(MID_DEPTH + 1);
  localparam logic [4:0]    LAST_CHANNEL = 5'(SERVO_COUNT);
  localparam logic [SB:0]   FULL_SCALE   = (SB + 1)'((1 << SB) - 1);
  localparam logic [CNT_W:0] MID_LIMIT   = (CNT_W + 1)'(MID_DEPTH);

  logic              accept;
  logic              is_servo;
  logic [PROD_W-1:0] scaled;
  logic [AW-1:0]     quot_est;
  logic [SB:0]       rem_est;
  logic [AW-1:0]     quot;
  jsp_pkg::work_t    work;
  logic              f_valid;
  logic [CNT_W:0]    occupancy;

  assign occupancy = {1'b0, mid_count} + (CNT_W + 1)'(f_valid);
  assign full      = rst | (occupancy >= MID_LIMIT);
  assign accept    = push & ~full;

  assign is_servo = (item.channel != jsp_pkg::STEPPER_CHANNEL) &&
                    (5'(item.channel) <= LAST_CHANNEL);

  // Divide 180*sample by the full scale 2^SB-1: the quotient by 2^SB
  // undershoots by at most one, and the remainder stays below twice the divisor.
  assign scaled   = PROD_W'(item.sample) * PROD_W'(jsp_pkg::ANGLE_MAX);
  assign quot_est = scaled[PROD_W-1:SB];
  assign rem_est  = (SB + 1)'(scaled[SB-1:0]) + (SB + 1)'(quot_est);
  assign quot     = (rem_est >= FULL_SCALE) ? quot_est + 1'b1 : quot_est;

  always_comb begin
    work             = '0;
    work.servo_index = item.channel - 3'd1;
    work.report      = is_servo && (item.channel == cfg.report_channel);
    work.abs_angle   = (item.channel == jsp_pkg::MIRROR_CHANNEL) ?
                       jsp_pkg::ANGLE_MAX - quot : quot;

    priority if (item.sample > cfg.raise_threshold) begin
      work.nudge = jsp_pkg::NUDGE_UP;
    end else if (item.sample > cfg.lower_threshold &&
                 item.sample < cfg.raise_threshold) begin
      work.nudge = jsp_pkg::NUDGE_HOLD;
    end else begin
      work.nudge = jsp_pkg::NUDGE_DOWN;
    end

    priority if (item.channel == jsp_pkg::STEPPER_CHANNEL) begin
      if (item.sample < cfg.step_back_threshold) begin
        work.op = jsp_pkg::OP_STEP_BACK;
      end else if (item.sample > cfg.step_fwd_threshold) begin
        work.op = jsp_pkg::OP_STEP_FWD;
      end else begin
        work.op = jsp_pkg::OP_NONE;
      end
    end else if (is_servo) begin
      work.op = cfg.fine_mode ? jsp_pkg::OP_SERVO_FINE : jsp_pkg::OP_SERVO_ABS;
    end else begin
      work.op = jsp_pkg::OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_item <= work;
    end
  end

  assign mid_push = f_valid;

endmodule

### design/jsp_back.sv
// Back part: updates servo angles and the stepper direction, forms the result.
module jsp_back #(
  parameter int SERVO_COUNT = 6,
  parameter int OUT_DEPTH   = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  jsp_pkg::cfg_t                  cfg,
  input  logic                           mid_empty,
  input  jsp_pkg::work_t                 mid_item,
  output logic                           mid_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           out_push,
  output jsp_pkg::result_t               out_item
);

  localparam int AW    = jsp_pkg::ANGLE_W;
  localparam int PW    = jsp_pkg::PULSE_W;
  localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [CNT_W:0] OUT_LIMIT = (CNT_W + 1)'(OUT_DEPTH);

  typedef struct packed {
    logic          update;
    logic [2:0]    index;
    logic [AW-1:0] angle;
    logic          step;
    logic          dir;
    logic          report;
  } stage_t;

  logic [AW-1:0] servo_angle [SERVO_COUNT];
  logic          dir_level;
  logic          dir_level_next;
  logic [IDX_W-1:0] idx;
  logic [AW-1:0] cur_angle;
  logic [AW-1:0] nudged;
  logic          write_angle;
  logic [AW-1:0] new_angle;
  logic [CNT_W:0] occupancy;
  stage_t        stage;
  stage_t        stage_next;
  logic          a_valid;
  logic [PW-1:0] product;

  // Credit check: the result queue must hold the item already in flight.
  assign occupancy = {1'b0, out_count} + (CNT_W + 1)'(a_valid);
  assign mid_pop   = ~mid_empty & (occupancy < OUT_LIMIT);

  assign idx       = IDX_W'(mid_item.servo_index);
  assign cur_angle = servo_angle[idx];

  always_comb begin
    unique case (mid_item.nudge)
      jsp_pkg::NUDGE_UP:
        nudged = (cur_angle < jsp_pkg::ANGLE_MAX) ? cur_angle + 1'b1 : jsp_pkg::ANGLE_MAX;
      jsp_pkg::NUDGE_DOWN:
        nudged = (cur_angle != '0) ? cur_angle - 1'b1 : '0;
      default:
        nudged = cur_angle;
    endcase
  end

  always_comb begin
    dir_level_next    = dir_level;
    write_angle       = 1'b0;
    new_angle         = mid_item.abs_angle;
    stage_next        = '0;
    unique case (mid_item.op)
      jsp_pkg::OP_STEP_BACK: begin
        dir_level_next  = 1'b0;
        stage_next.step = 1'b1;
      end
      jsp_pkg::OP_STEP_FWD: begin
        dir_level_next  = 1'b1;
        stage_next.step = 1'b1;
      end
      jsp_pkg::OP_SERVO_ABS: begin
        write_angle = 1'b1;
      end
      jsp_pkg::OP_SERVO_FINE: begin
        write_angle = 1'b1;
        new_angle   = nudged;
      end
      default: begin
      end
    endcase
    stage_next.update = write_angle;
    stage_next.index  = write_angle ? mid_item.servo_index : 3'd0;
    stage_next.angle  = new_angle;
    stage_next.dir    = dir_level_next;
    stage_next.report = mid_item.report;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_level <= 1'b0;
      a_valid   <= 1'b0;
      for (int i = 0; i < SERVO_COUNT; i++) begin
        servo_angle[i] <= '0;
      end
    end else begin
      a_valid <= mid_pop;
      if (mid_pop) begin
        dir_level <= dir_level_next;
        if (write_angle) begin
          servo_angle[idx] <= new_angle;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      stage <= stage_next;
    end
  end

  assign product = PW'(cfg.ticks_per_degree) * PW'(stage.angle);

  always_comb begin
    out_item              = '0;
    out_item.servo_update = stage.update;
    out_item.servo_index  = stage.index;
    out_item.pulse_ticks  = stage.update ? PW'(cfg.pulse_base) + product : '0;
    out_item.step_pulse   = stage.step;
    out_item.step_dir     = stage.dir;
    out_item.report_valid = stage.report;
    out_item.report_angle = stage.report ? stage.angle : '0;
  end

  assign out_push = a_valid;

endmodule

### design/joystick_servo_positioner_core.sv
// Top level of the joystick servo positioner: configuration registers and the two queues.
//
// Usage: joystick samples enter as a queue push (push, full, item); each accepted
// sample yields exactly one result, read as a queue (empty, pop, result), oldest
// first. Channel 0 steps the stepper; channels 1 to SERVO_COUNT set servo angles
// and give a pulse width. Registers are written on the cfg channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data); write them only while no sample is in flight,
// as the block itself does not enforce this. Path: an accepted sample passes the
// front register, mid queue, back stage, then result queue before empty goes low.
// Throughput: one sample per cycle, sustained, as long as results are popped;
// the back stage updates the angle store as it takes each item, so the next sees it.
// Stalls: when pop stays low the result queue fills, the back part stops taking
// work, the mid queue fills, and full rises; nothing is lost.
// Reset: synchronous; empties both queues, zeroes all servo angles and the
// stepper direction, and loads every register with its default. full is high
// and empty is high while reset is asserted.
module joystick_servo_positioner_core #(
  parameter int SERVO_COUNT = 6,
  parameter int MID_DEPTH   = 4,
  parameter int OUT_DEPTH   = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  jsp_pkg::in_item_t                  item,
  output logic                               full,
  input  logic                               pop,
  output logic                               empty,
  output jsp_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [jsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [jsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  jsp_pkg::cfg_t            cfg;
  logic                     mid_push;
  logic                     mid_pop;
  jsp_pkg::work_t           mid_wdata;
  jsp_pkg::work_t           mid_rdata;
  logic [MID_CNT_W-1:0]     mid_count;
  logic                     out_push;
  jsp_pkg::result_t         out_wdata;
  logic [OUT_CNT_W-1:0]     out_count;

  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fine_mode           <= jsp_pkg::RESET_FINE_MODE;
      cfg.report_channel      <= jsp_pkg::RESET_REPORT_CHANNEL;
      cfg.raise_threshold     <= jsp_pkg::RESET_RAISE;
      cfg.lower_threshold     <= jsp_pkg::RESET_LOWER;
      cfg.step_back_threshold <= jsp_pkg::RESET_STEP_BACK;
      cfg.step_fwd_threshold  <= jsp_pkg::RESET_STEP_FWD;
      cfg.pulse_base          <= jsp_pkg::RESET_PULSE_BASE;
      cfg.ticks_per_degree    <= jsp_pkg::RESET_TICKS_PER_DEG;
    end else if (cfg_valid && cfg_ready) begin
      unique case (jsp_pkg::reg_index_t'(cfg_index))
        jsp_pkg::REG_FINE_MODE:           cfg.fine_mode <= cfg_data[0];
        jsp_pkg::REG_REPORT_CHANNEL:      cfg.report_channel <= cfg_data[2:0];
        jsp_pkg::REG_RAISE_THRESHOLD:     cfg.raise_threshold <= cfg_data;
        jsp_pkg::REG_LOWER_THRESHOLD:     cfg.lower_threshold <= cfg_data;
        jsp_pkg::REG_STEP_BACK_THRESHOLD: cfg.step_back_threshold <= cfg_data;
        jsp_pkg::REG_STEP_FWD_THRESHOLD:  cfg.step_fwd_threshold <= cfg_data;
        jsp_pkg::REG_PULSE_BASE:          cfg.pulse_base <= cfg_data;
        jsp_pkg::REG_TICKS_PER_DEGREE:    cfg.ticks_per_degree <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  jsp_front #(
    .SERVO_COUNT(SERVO_COUNT),
    .MID_DEPTH  (MID_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cfg      (cfg),
    .mid_count(mid_count),
    .mid_push (mid_push),
    .mid_item (mid_wdata)
  );

  jsp_fifo #(
    .WIDTH($bits(jsp_pkg::work_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (mid_push),
    .wdata(mid_wdata),
    .pop  (mid_pop),
    .rdata(mid_rdata),
    .count(mid_count)
  );

  jsp_back #(
    .SERVO_COUNT(SERVO_COUNT),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .mid_empty(mid_count == '0),
    .mid_item (mid_rdata),
    .mid_pop  (mid_pop),
    .out_count(out_count),
    .out_push (out_push),
    .out_item (out_wdata)
  );

  jsp_fifo #(
    .WIDTH($bits(jsp_pkg::result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .wdata(out_wdata),
    .pop  (pop & ~empty),
    .rdata(result),
    .count(out_count)
  );

  assign empty = rst | (out_count == '0);

endmodule

### design/jsp_checker.sv
// Port-level checks on the result side of the positioner, bound to the top level.
module jsp_checker (
  input logic             clk,
  input logic             rst,
  input logic             pop,
  input logic             empty,
  input jsp_pkg::result_t result
);

  // A waiting result that is not taken stays on the ports unchanged.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("result changed or vanished while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    !empty && !result.servo_update |->
      result.pulse_ticks == '0 && result.servo_index == '0 && !result.report_valid)
    else $error("servo fields set on a result without a servo transfer");

  a_step_alone: assert property (@(posedge clk) disable iff (rst)
    !empty && result.step_pulse |-> !result.servo_update && !result.report_valid)
    else $error("stepper pulse combined with a servo update");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    !empty && result.report_valid |-> result.report_angle <= jsp_pkg::ANGLE_MAX)
    else $error("reported angle beyond full travel");

endmodule

bind joystick_servo_positioner_core jsp_checker u_jsp_checker (.*);

### verif/joystick_servo_positioner_core_test.sv
// Self-checking testbench for the joystick servo positioner core.
`timescale 1ns / 100ps

module joystick_servo_positioner_core_test;

  localparam int SERVO_COUNT = 6;
  localparam int FULL_SCALE  = (1 << jsp_pkg::SAMPLE_BITS) - 1;
  localparam int SETTLE_CYCLES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  jsp_pkg::in_item_t sample_item = '0;
  logic full;
  logic pop = 1'b0;
  logic empty;
  jsp_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [jsp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [jsp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: register copy, servo angles and stepper direction.
  jsp_pkg::cfg_t model_cfg = '{
    fine_mode:           jsp_pkg::RESET_FINE_MODE,
    report_channel:      jsp_pkg::RESET_REPORT_CHANNEL,
    raise_threshold:     jsp_pkg::RESET_RAISE,
    lower_threshold:     jsp_pkg::RESET_LOWER,
    step_back_threshold: jsp_pkg::RESET_STEP_BACK,
    step_fwd_threshold:  jsp_pkg::RESET_STEP_FWD,
    pulse_base:          jsp_pkg::RESET_PULSE_BASE,
    ticks_per_degree:    jsp_pkg::RESET_TICKS_PER_DEG
  };
  logic [jsp_pkg::ANGLE_W-1:0] model_angle [SERVO_COUNT] = '{default: '0};
  logic model_dir = 1'b0;

  jsp_pkg::result_t pending_results [$];
  int idle_pct = 30;
  int error_count = 0;
  int items_sent = 0;
  int servo_updates = 0;
  int step_count = 0;
  int report_count = 0;
  int reg_writes = 0;

  joystick_servo_positioner_core dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(sample_item),
    .full(full),
    .pop(pop),
    .empty(empty),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= idle_pct);
  end

  function automatic jsp_pkg::result_t predict_result(input jsp_pkg::in_item_t it);
    jsp_pkg::result_t r;
    jsp_pkg::nudge_t dec;
    int angle;
    int k;
    r = '0;
    if (it.channel == jsp_pkg::STEPPER_CHANNEL) begin
      if (it.sample < model_cfg.step_back_threshold) begin
        model_dir = 1'b0;
        r.step_pulse = 1'b1;
      end else if (it.sample > model_cfg.step_fwd_threshold) begin
        model_dir = 1'b1;
        r.step_pulse = 1'b1;
      end
    end else if (it.channel <= SERVO_COUNT) begin
      k = int'(it.channel) - 1;
      if (model_cfg.fine_mode) begin
        angle = int'(model_angle[k]);
        if (it.sample > model_cfg.raise_threshold) dec = jsp_pkg::NUDGE_UP;
        else if (it.sample > model_cfg.lower_threshold &&
                 it.sample < model_cfg.raise_threshold) dec = jsp_pkg::NUDGE_HOLD;
        else dec = jsp_pkg::NUDGE_DOWN;
        if (dec == jsp_pkg::NUDGE_UP && angle < int'(jsp_pkg::ANGLE_MAX)) angle++;
        if (dec == jsp_pkg::NUDGE_DOWN && angle > 0) angle--;
      end else begin
        angle = (int'(jsp_pkg::ANGLE_MAX) * int'(it.sample)) / FULL_SCALE;
        if (it.channel == jsp_pkg::MIRROR_CHANNEL) angle = int'(jsp_pkg::ANGLE_MAX) - angle;
      end
      model_angle[k] = angle[jsp_pkg::ANGLE_W-1:0];
      r.servo_update = 1'b1;
      r.servo_index = k[2:0];
      r.pulse_ticks = jsp_pkg::PULSE_W'(int'(model_cfg.pulse_base) +
                                        int'(model_cfg.ticks_per_degree) * angle);
      if (it.channel == model_cfg.report_channel) begin
        r.report_valid = 1'b1;
        r.report_angle = angle[jsp_pkg::ANGLE_W-1:0];
      end
    end
    r.step_dir = model_dir;
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    jsp_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result waiting: %p", result);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.servo_update !== want.servo_update) begin
          $error("servo_update: expected %0d, got %0d", want.servo_update, result.servo_update);
          error_count++;
        end
        if (result.servo_index !== want.servo_index) begin
          $error("servo_index: expected %0d, got %0d", want.servo_index, result.servo_index);
          error_count++;
        end
        if (result.pulse_ticks !== want.pulse_ticks) begin
          $error("pulse_ticks: expected %0d, got %0d", want.pulse_ticks, result.pulse_ticks);
          error_count++;
        end
        if (result.step_pulse !== want.step_pulse) begin
          $error("step_pulse: expected %0d, got %0d", want.step_pulse, result.step_pulse);
          error_count++;
        end
        if (result.step_dir !== want.step_dir) begin
          $error("step_dir: expected %0d, got %0d", want.step_dir, result.step_dir);
          error_count++;
        end
        if (result.report_valid !== want.report_valid) begin
          $error("report_valid: expected %0d, got %0d", want.report_valid, result.report_valid);
          error_count++;
        end
        if (result.report_angle !== want.report_angle) begin
          $error("report_angle: expected %0d, got %0d", want.report_angle, result.report_angle);
          error_count++;
        end
      end
    end
  end

  // All tasks start and end at a falling edge.
  task automatic drive_sample(input int ch, input int smp);
    jsp_pkg::in_item_t it;
    jsp_pkg::result_t want;
    it.channel = ch[jsp_pkg::CHANNEL_W-1:0];
    it.sample = smp[jsp_pkg::SAMPLE_BITS-1:0];
    if ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    push <= 1'b1;
    sample_item <= it;
    do @(posedge clk); while (full);
    want = predict_result(it);
    pending_results.push_back(want);
    items_sent++;
    servo_updates += want.servo_update;
    step_count += want.step_pulse;
    report_count += want.report_valid;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Caller makes sure the block is drained first. The write channel goes idle
  // after each transfer.
  task automatic write_register(input jsp_pkg::reg_index_t idx, input int value);
    logic [jsp_pkg::CFG_DATA_W-1:0] data;
    data = value[jsp_pkg::CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      jsp_pkg::REG_FINE_MODE:
        model_cfg.fine_mode = data[0];
      jsp_pkg::REG_REPORT_CHANNEL:
        model_cfg.report_channel = data[jsp_pkg::CHANNEL_W-1:0];
      jsp_pkg::REG_RAISE_THRESHOLD:     model_cfg.raise_threshold = data;
      jsp_pkg::REG_LOWER_THRESHOLD:     model_cfg.lower_threshold = data;
      jsp_pkg::REG_STEP_BACK_THRESHOLD: model_cfg.step_back_threshold = data;
      jsp_pkg::REG_STEP_FWD_THRESHOLD:  model_cfg.step_fwd_threshold = data;
      jsp_pkg::REG_PULSE_BASE:          model_cfg.pulse_base = data;
      jsp_pkg::REG_TICKS_PER_DEGREE:
        model_cfg.ticks_per_degree = data[jsp_pkg::TPD_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return FULL_SCALE;
      default: return $urandom_range(0, FULL_SCALE);
    endcase
  endfunction

  // Mostly random codes, with weight on the ends of the range and on threshold edges.
  function automatic int pick_sample();
    int th;
    int smp;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return FULL_SCALE;
      2, 3, 4: begin
        case ($urandom_range(0, 3))
          0: th = model_cfg.raise_threshold;
          1: th = model_cfg.lower_threshold;
          2: th = model_cfg.step_back_threshold;
          default: th = model_cfg.step_fwd_threshold;
        endcase
        smp = th + $urandom_range(0, 2) - 1;
        if (smp < 0) smp = 0;
        if (smp > FULL_SCALE) smp = FULL_SCALE;
        return smp;
      end
      default: return $urandom_range(0, FULL_SCALE);
    endcase
  endfunction

  // A sample that pushes the given channel up or down under the current settings.
  function automatic int run_sample(input int ch, input bit go_high);
    int hi_th;
    int lo_th;
    hi_th = (ch == 0) ? model_cfg.step_fwd_threshold : model_cfg.raise_threshold;
    lo_th = (ch == 0) ? model_cfg.step_back_threshold : model_cfg.lower_threshold;
    if (go_high) return (hi_th < FULL_SCALE) ? $urandom_range(hi_th + 1, FULL_SCALE) : FULL_SCALE;
    if (ch != 0) return $urandom_range(0, lo_th);
    return (lo_th > 0) ? $urandom_range(0, lo_th - 1) : 0;
  endfunction

  task automatic test_reset_defaults();
    int ch;
    int step_codes [6];
    step_codes = '{0, 1499, 1500, 2500, 2501, FULL_SCALE};
    foreach (step_codes[i]) drive_sample(0, step_codes[i]);
    for (ch = 1; ch <= SERVO_COUNT; ch++) drive_sample(ch, FULL_SCALE);
    drive_sample(2, 0);
    drive_sample(2, 2048);
    drive_sample(5, 2048);
    drive_sample(1, 0);
    // Channel seven has no servo behind it.
    drive_sample(7, FULL_SCALE);
    drive_sample(7, 0);
    wait_drained();
  endtask

  task automatic test_fine_mode();
    write_register(jsp_pkg::REG_REPORT_CHANNEL, 1);
    drive_sample(1, FULL_SCALE);
    drive_sample(2, FULL_SCALE);
    wait_drained();
    write_register(jsp_pkg::REG_FINE_MODE, 1);
    drive_sample(1, FULL_SCALE);   // already at the top, stays there
    drive_sample(2, 0);            // mirrored to zero, stays there
    drive_sample(1, 3000);         // equal to the raise edge lowers
    drive_sample(1, 1000);         // equal to the lower edge lowers
    drive_sample(1, 1001);
    drive_sample(1, 2999);
    drive_sample(2, 3001);         // nudged up, not mirrored
    drive_sample(3, FULL_SCALE);
    drive_sample(7, 3001);
    drive_sample(0, 0);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_register(jsp_pkg::REG_RAISE_THRESHOLD, 0);
    write_register(jsp_pkg::REG_LOWER_THRESHOLD, FULL_SCALE);
    write_register(jsp_pkg::REG_STEP_BACK_THRESHOLD, 0);
    write_register(jsp_pkg::REG_STEP_FWD_THRESHOLD, FULL_SCALE);
    write_register(jsp_pkg::REG_PULSE_BASE, FULL_SCALE);
    write_register(jsp_pkg::REG_TICKS_PER_DEGREE, 63);
    write_register(jsp_pkg::REG_REPORT_CHANNEL, 7);
    drive_sample(0, 0);
    drive_sample(0, FULL_SCALE);
    drive_sample(1, 0);
    drive_sample(1, FULL_SCALE);
    wait_drained();
    write_register(jsp_pkg::REG_FINE_MODE, 0);
    write_register(jsp_pkg::REG_REPORT_CHANNEL, 6);
    drive_sample(6, FULL_SCALE);
    wait_drained();
    write_register(jsp_pkg::REG_REPORT_CHANNEL, 0);
    write_register(jsp_pkg::REG_STEP_BACK_THRESHOLD, FULL_SCALE);
    write_register(jsp_pkg::REG_STEP_FWD_THRESHOLD, 0);
    write_register(jsp_pkg::REG_TICKS_PER_DEGREE, 0);
    write_register(jsp_pkg::REG_PULSE_BASE, 0);
    drive_sample(0, 2000);
    drive_sample(0, FULL_SCALE);
    drive_sample(3, FULL_SCALE);
    drive_sample(4, 0);
    wait_drained();
  endtask

  task automatic randomize_settings();
    int raise_th;
    int lower_th;
    int back_th;
    int fwd_th;
    int swap;
    raise_th = pick_threshold();
    lower_th = pick_threshold();
    back_th = pick_threshold();
    fwd_th = pick_threshold();
    // Keep the bands ordered most of the time so that all three outcomes happen.
    if ($urandom_range(0, 3) != 0 && lower_th > raise_th) begin
      swap = lower_th; lower_th = raise_th; raise_th = swap;
    end
    if ($urandom_range(0, 3) != 0 && back_th > fwd_th) begin
      swap = back_th; back_th = fwd_th; fwd_th = swap;
    end
    wait_drained();
    write_register(jsp_pkg::REG_FINE_MODE, $urandom_range(0, FULL_SCALE));
    write_register(jsp_pkg::REG_REPORT_CHANNEL, $urandom_range(0, FULL_SCALE));
    write_register(jsp_pkg::REG_RAISE_THRESHOLD, raise_th);
    write_register(jsp_pkg::REG_LOWER_THRESHOLD, lower_th);
    write_register(jsp_pkg::REG_STEP_BACK_THRESHOLD, back_th);
    write_register(jsp_pkg::REG_STEP_FWD_THRESHOLD, fwd_th);
    write_register(jsp_pkg::REG_PULSE_BASE, pick_threshold());
    write_register(jsp_pkg::REG_TICKS_PER_DEGREE,
                   ($urandom_range(0, 4) == 0) ? 63 * $urandom_range(0, 1)
                                               : $urandom_range(0, FULL_SCALE));
  endtask

  task automatic test_random_stream(input int phase_count, input int phase_items);
    int p;
    int sent;
    int ch;
    int len;
    bit go_high;
    bit paused;
    paused = 1'b0;
    for (p = 0; p < phase_count; p++) begin
      randomize_settings();
      idle_pct = (p == 2) ? 0 : 30;
      sent = 0;
      while (sent < phase_items) begin
        if (p == 4 && !paused && sent >= phase_items / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 60) begin
          // A run on one joystick held to one side, sometimes long enough to hit the angle limits.
          ch = $urandom_range(0, SERVO_COUNT);
          go_high = $urandom_range(0, 1);
          len = $urandom_range(4, ($urandom_range(0, 4) == 0) ? 200 : 30);
          if (len > phase_items - sent) len = phase_items - sent;
          repeat (len) begin
            drive_sample(ch, run_sample(ch, go_high));
            sent++;
          end
        end else begin
          drive_sample($urandom_range(0, 7), pick_sample());
          sent++;
        end
      end
    end
    idle_pct = 30;
    wait_drained();
  endtask

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_fine_mode();
    test_register_extremes();
    test_random_stream(8, 192);
    wait_drained();
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    $display("Sent %0d samples: %0d servo updates, %0d steps, %0d angle reports.",
             items_sent, servo_updates, step_count, report_count);
    $display("Made %0d register writes across absolute and fine settings, extremes included.",
             reg_writes);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
